>>> hw/rtl/pfs_pkg.sv
package pfs_pkg;

  // Fit limits and fixed-point formats
  localparam int MAX_POINTS      = 256;
  localparam int COORD_FRAC_BITS = 16;
  localparam int SLOPE_FRAC_BITS = 24;

  // Pipeline depths of the multiplier and divider units
  localparam int MUL_LAT = 5;
  localparam int QBITS   = 32;
  localparam int DIV_LAT = QBITS + 1;

  // Round-half-away result already in q; clamp to the signed 32-bit range and apply sign.
  function automatic logic [31:0] round_sat(input logic [31:0] q, input logic ovf,
                                            input logic neg);
    logic [31:0] lim;
    logic [31:0] m;
    lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    m   = (ovf || (q > lim)) ? lim : q;
    return neg ? (32'd0 - m) : m;
  endfunction

endpackage

>>> hw/rtl/pfs_mul.sv
module pfs_mul #(
  parameter int WA = 8,
  parameter int WB = 8
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [WA-1:0] a_i,
  input  logic signed [WB-1:0] b_i,
  output logic signed [WA+WB-1:0] p_o
);
  import pfs_pkg::*;

  localparam int CA  = (WA + 31) / 32;
  localparam int CB  = (WB + 31) / 32;
  localparam int RW  = 32 * CB + 32;
  localparam int PW2 = 32 * CA + 32 * CB;

  logic [WA-1:0]       aa;
  logic [WB-1:0]       bb;
  logic [32*CA-1:0]    ma_q;
  logic [32*CB-1:0]    mb_q;
  logic [MUL_LAT-2:0]  sg_q;
  logic [63:0]         pp_q [CA][CB];
  logic [RW-1:0]       row_q [CA];
  logic [PW2-1:0]      acc;
  logic [PW2-1:0]      mag_q;
  logic [WA+WB-1:0]    mt;
  logic signed [WA+WB-1:0] p_q;

  assign aa = a_i[WA-1] ? WA'(-a_i) : WA'(a_i);
  assign bb = b_i[WB-1] ? WB'(-b_i) : WB'(b_i);

  // stage 1: magnitudes and sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q <= (32*CA)'(aa);
      mb_q <= (32*CB)'(bb);
      sg_q <= {sg_q[MUL_LAT-3:0], a_i[WA-1] ^ b_i[WB-1]};
    end
  end

  // stage 2: 32x32 partial products; stage 3: row sums
  for (genvar i = 0; i < CA; i++) begin : g_row
    logic [RW-1:0] ev;
    logic [RW-1:0] od;
    for (genvar j = 0; j < CB; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pp_q[i][j] <= ma_q[32*i +: 32] * mb_q[32*j +: 32];
        end
      end
    end
    // even and odd columns do not overlap, so each row is one add
    always_comb begin
      ev = '0;
      od = '0;
      for (int j = 0; j < CB; j++) begin
        if (j % 2 == 0) ev[32*j +: 64] = pp_q[i][j];
        else            od[32*j +: 64] = pp_q[i][j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        row_q[i] <= ev + od;
      end
    end
  end

  // stage 4: sum rows
  always_comb begin
    acc = '0;
    for (int i = 0; i < CA; i++) begin
      acc = acc + (PW2'(row_q[i]) << (32 * i));
    end
  end

  assign mt = mag_q[WA+WB-1:0];

  // stage 5: apply sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= acc;
      p_q   <= sg_q[MUL_LAT-2] ? (WA+WB)'(0 - mt) : mt;
    end
  end

  assign p_o = p_q;

endmodule

>>> hw/rtl/pfs_div.sv
module pfs_div #(
  parameter int WN = 8,
  parameter int WD = 8
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [WN-1:0]             num_i,
  input  logic [WD-1:0]             den_i,
  output logic [pfs_pkg::QBITS-1:0] q_o,
  output logic                      ovf_o
);
  import pfs_pkg::*;

  localparam int W = (WN > WD + QBITS) ? WN : WD + QBITS;

  logic [W-1:0]     r_q   [QBITS];
  logic [WD-1:0]    d_q   [QBITS];
  logic [QBITS-1:0] q_q   [QBITS+1];
  logic             ovf_q [QBITS+1];

  // stage 0: quotient at or above 2^QBITS saturates
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= W'(num_i);
      d_q[0]   <= den_i;
      q_q[0]   <= '0;
      ovf_q[0] <= W'(num_i) >= (W'(den_i) << QBITS);
    end
  end

  // one restoring step per stage, MSB first
  for (genvar k = 1; k <= QBITS; k++) begin : g_step
    localparam int SH = QBITS - k;
    logic [W-1:0] dsh;
    logic         take;
    assign dsh  = W'(d_q[k-1]) << SH;
    assign take = r_q[k-1] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k]   <= {q_q[k-1][QBITS-2:0], take};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
    if (k < QBITS) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k] <= take ? (r_q[k-1] - dsh) : r_q[k-1];
          d_q[k] <= d_q[k-1];
        end
      end
    end
  end

  assign q_o   = q_q[QBITS];
  assign ovf_o = ovf_q[QBITS];

endmodule

>>> hw/rtl/plane_fit_solver.sv
// Least-squares plane fit z = -(A x + B y + D) from accumulated point sums.
//
// Request channel: in_valid_i / in_stall_o with the sums as separate ports,
// taken at a clock edge with valid high and stall low. Result channel:
// out_valid_o / out_stall_i with slope_a_o, slope_b_o (Q8.24), offset_d_o
// (Q.16) and fit_failed_o. A failed fit returns zero coefficients.
// cfg_we_i writes cfg_wdata_i into the singular tolerance (reset value 1);
// write it only while no request is in flight.
//
// Throughput: one request per cycle while no stalled result waits. The
// depth is three 5-stage pipelined multiplier rounds for covariances,
// determinant and offset numerator, followed by 33-stage restoring
// dividers (an overflow check, then one quotient bit per stage).
// The whole pipeline advances together; when the receiver stalls a valid
// result, the pipe holds and in_stall_o rises in the same cycle. Reset
// empties the pipeline and restores the tolerance register.
module plane_fit_solver (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [8:0]         point_count_i,
  input  logic signed [34:0] sum_x_i,
  input  logic signed [34:0] sum_y_i,
  input  logic signed [34:0] sum_z_i,
  input  logic [59:0]        sum_xx_i,
  input  logic [59:0]        sum_yy_i,
  input  logic signed [60:0] sum_xy_i,
  input  logic signed [60:0] sum_yz_i,
  input  logic signed [60:0] sum_xz_i,
  input  logic [26:0]        max_abs_x_i,
  input  logic [26:0]        max_abs_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] slope_a_o,
  output logic signed [31:0] slope_b_o,
  output logic signed [31:0] offset_d_o,
  output logic               fit_failed_o
);
  import pfs_pkg::*;

  localparam int NW   = 10;
  localparam int SW   = 35;
  localparam int PW   = 61;
  localparam int CW   = NW + PW;
  localparam int DW   = 2 * CW;
  localparam int EW   = SW + DW;
  localparam int NDW  = NW + DW;
  localparam int TMW  = 17 + 29;
  localparam int N2W  = 2 * NW;
  localparam int N4W  = 2 * N2W;
  localparam int THW  = TMW + N4W;
  localparam int ANW  = DW + SLOPE_FRAC_BITS;

  localparam int S_A = MUL_LAT;
  localparam int S_B = S_A + 1;
  localparam int S_C = S_B + MUL_LAT;
  localparam int S_D = S_C + 1;
  localparam int S_E = S_D + MUL_LAT;
  localparam int S_F = S_E + 1;
  localparam int S_G = S_F + 1;
  localparam int S_H = S_G + 1;
  localparam int S_Q = S_H + DIV_LAT;
  localparam int S_O = S_Q + 1;

  logic        en;
  logic [S_O:0] v_q;
  logic [15:0] tol_q;

  // input stage and side delays
  logic signed [NW-1:0] n_q  [S_D+1];
  logic signed [SW-1:0] sx_q [S_D+1];
  logic signed [SW-1:0] sy_q [S_D+1];
  logic signed [SW-1:0] sz_q [S_D+1];
  logic                 f0_q [S_F];
  logic signed [PW-1:0] sxx_q, syy_q, sxy_q, syz_q, sxz_q;
  logic [27:0]          ms_q;

  // covariance products
  logic signed [CW-1:0]   pxx, pyy, pxy, pyz, pxz;
  logic signed [2*SW-1:0] qxx, qyy, qxy, qyz, qxz;
  logic signed [N2W-1:0]  pn2;
  logic signed [TMW-1:0]  ptm;
  logic signed [CW-1:0]   cxx_q, cyy_q, cxy_q, cyz_q, cxz_q;
  logic signed [N2W-1:0]  n2_q;
  logic signed [TMW-1:0]  tm_q [MUL_LAT+2];

  // determinant round
  logic signed [DW-1:0]  pd1, pd2, pa1, pa2, pb1, pb2;
  logic signed [N4W-1:0] pn4;
  logic signed [N4W-1:0] n4_q;
  logic signed [DW-1:0]  den_q  [MUL_LAT+2];
  logic signed [DW-1:0]  numa_q [MUL_LAT+2];
  logic signed [DW-1:0]  numb_q [MUL_LAT+2];
  logic [DW-1:0]         dab_q  [MUL_LAT];

  // offset round
  logic signed [EW-1:0]  pe1, pe2, pe3;
  logic signed [NDW-1:0] pnd;
  logic signed [THW-1:0] pth;
  logic [DW-1:0]         thr;
  logic signed [EW-1:0]  numd_q;
  logic signed [NDW-1:0] nd_q;
  logic                  fail_f_q;

  // divider setup
  logic signed [ANW-1:0] sha, shb;
  logic [ANW-1:0]        ana_q, anb_q;
  logic [DW-1:0]         ad_q;
  logic [EW-1:0]         and_q;
  logic [NDW-1:0]        anden_q;
  logic [2:0]            ng_q;
  logic                  fail_g_q;
  logic [ANW:0]          na_q, nb_q;
  logic [DW:0]           dab2_q;
  logic [EW:0]           nnd_q;
  logic [NDW:0]          dnd_q;
  logic [3:0]            fl_q [DIV_LAT+1];

  logic [QBITS-1:0] qa, qb, qd;
  logic             ova, ovb, ovd;

  logic signed [31:0] slope_a_q, slope_b_q, offset_d_q;
  logic               fit_failed_q;

  // hold the whole pipe while a result waits on a stalled receiver
  assign en         = !v_q[S_O] || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 16'd1;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[S_O-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q[0]  <= {1'b0, point_count_i};
      sx_q[0] <= sum_x_i;
      sy_q[0] <= sum_y_i;
      sz_q[0] <= sum_z_i;
      f0_q[0] <= (point_count_i == '0) || (int'(point_count_i) > MAX_POINTS);
      sxx_q   <= {1'b0, sum_xx_i};
      syy_q   <= {1'b0, sum_yy_i};
      sxy_q   <= sum_xy_i;
      syz_q   <= sum_yz_i;
      sxz_q   <= sum_xz_i;
      ms_q    <= 28'(max_abs_x_i) + 28'(max_abs_y_i);
      for (int k = 1; k <= S_D; k++) begin
        n_q[k]  <= n_q[k-1];
        sx_q[k] <= sx_q[k-1];
        sy_q[k] <= sy_q[k-1];
        sz_q[k] <= sz_q[k-1];
      end
      for (int k = 1; k < S_F; k++) begin
        f0_q[k] <= f0_q[k-1];
      end
    end
  end

  pfs_mul #(.WA(NW), .WB(PW)) u_mul_pxx (.clk_i, .en_i(en), .a_i(n_q[0]), .b_i(sxx_q), .p_o(pxx));
  pfs_mul #(.WA(NW), .WB(PW)) u_mul_pyy (.clk_i, .en_i(en), .a_i(n_q[0]), .b_i(syy_q), .p_o(pyy));
  pfs_mul #(.WA(NW), .WB(PW)) u_mul_pxy (.clk_i, .en_i(en), .a_i(n_q[0]), .b_i(sxy_q), .p_o(pxy));
  pfs_mul #(.WA(NW), .WB(PW)) u_mul_pyz (.clk_i, .en_i(en), .a_i(n_q[0]), .b_i(syz_q), .p_o(pyz));
  pfs_mul #(.WA(NW), .WB(PW)) u_mul_pxz (.clk_i, .en_i(en), .a_i(n_q[0]), .b_i(sxz_q), .p_o(pxz));
  pfs_mul #(.WA(SW), .WB(SW)) u_mul_qxx (.clk_i, .en_i(en), .a_i(sx_q[0]), .b_i(sx_q[0]), .p_o(qxx));
  pfs_mul #(.WA(SW), .WB(SW)) u_mul_qyy (.clk_i, .en_i(en), .a_i(sy_q[0]), .b_i(sy_q[0]), .p_o(qyy));
  pfs_mul #(.WA(SW), .WB(SW)) u_mul_qxy (.clk_i, .en_i(en), .a_i(sx_q[0]), .b_i(sy_q[0]), .p_o(qxy));
  pfs_mul #(.WA(SW), .WB(SW)) u_mul_qyz (.clk_i, .en_i(en), .a_i(sy_q[0]), .b_i(sz_q[0]), .p_o(qyz));
  pfs_mul #(.WA(SW), .WB(SW)) u_mul_qxz (.clk_i, .en_i(en), .a_i(sx_q[0]), .b_i(sz_q[0]), .p_o(qxz));
  pfs_mul #(.WA(NW), .WB(NW)) u_mul_n2 (.clk_i, .en_i(en), .a_i(n_q[0]), .b_i(n_q[0]), .p_o(pn2));
  pfs_mul #(.WA(17), .WB(29)) u_mul_tm (
    .clk_i, .en_i(en), .a_i({1'b0, tol_q}), .b_i({1'b0, ms_q}), .p_o(ptm)
  );

  // centred covariances scaled by n^2
  always_ff @(posedge clk_i) begin
    if (en) begin
      cxx_q   <= pxx - CW'(qxx);
      cyy_q   <= pyy - CW'(qyy);
      cxy_q   <= pxy - CW'(qxy);
      cyz_q   <= pyz - CW'(qyz);
      cxz_q   <= pxz - CW'(qxz);
      n2_q    <= pn2;
      tm_q[0] <= ptm;
      for (int k = 1; k < MUL_LAT + 2; k++) begin
        tm_q[k] <= tm_q[k-1];
      end
    end
  end

  pfs_mul #(.WA(CW), .WB(CW)) u_mul_d1 (.clk_i, .en_i(en), .a_i(cxx_q), .b_i(cyy_q), .p_o(pd1));
  pfs_mul #(.WA(CW), .WB(CW)) u_mul_d2 (.clk_i, .en_i(en), .a_i(cxy_q), .b_i(cxy_q), .p_o(pd2));
  pfs_mul #(.WA(CW), .WB(CW)) u_mul_a1 (.clk_i, .en_i(en), .a_i(cyz_q), .b_i(cxy_q), .p_o(pa1));
  pfs_mul #(.WA(CW), .WB(CW)) u_mul_a2 (.clk_i, .en_i(en), .a_i(cxz_q), .b_i(cyy_q), .p_o(pa2));
  pfs_mul #(.WA(CW), .WB(CW)) u_mul_b1 (.clk_i, .en_i(en), .a_i(cxz_q), .b_i(cxy_q), .p_o(pb1));
  pfs_mul #(.WA(CW), .WB(CW)) u_mul_b2 (.clk_i, .en_i(en), .a_i(cyz_q), .b_i(cxx_q), .p_o(pb2));
  pfs_mul #(.WA(N2W), .WB(N2W)) u_mul_n4 (.clk_i, .en_i(en), .a_i(n2_q), .b_i(n2_q), .p_o(pn4));

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q[0]  <= pd1 - pd2;
      numa_q[0] <= pa1 - pa2;
      numb_q[0] <= pb1 - pb2;
      n4_q      <= pn4;
      dab_q[0]  <= den_q[0][DW-1] ? DW'(-den_q[0]) : DW'(den_q[0]);
      for (int k = 1; k < MUL_LAT + 2; k++) begin
        den_q[k]  <= den_q[k-1];
        numa_q[k] <= numa_q[k-1];
        numb_q[k] <= numb_q[k-1];
      end
      for (int k = 1; k < MUL_LAT; k++) begin
        dab_q[k] <= dab_q[k-1];
      end
    end
  end

  pfs_mul #(.WA(SW), .WB(DW)) u_mul_e1 (
    .clk_i, .en_i(en), .a_i(sz_q[S_D]), .b_i(den_q[0]), .p_o(pe1)
  );
  pfs_mul #(.WA(SW), .WB(DW)) u_mul_e2 (
    .clk_i, .en_i(en), .a_i(sx_q[S_D]), .b_i(numa_q[0]), .p_o(pe2)
  );
  pfs_mul #(.WA(SW), .WB(DW)) u_mul_e3 (
    .clk_i, .en_i(en), .a_i(sy_q[S_D]), .b_i(numb_q[0]), .p_o(pe3)
  );
  pfs_mul #(.WA(NW), .WB(DW)) u_mul_nd (
    .clk_i, .en_i(en), .a_i(n_q[S_D]), .b_i(den_q[0]), .p_o(pnd)
  );
  pfs_mul #(.WA(TMW), .WB(N4W)) u_mul_th (
    .clk_i, .en_i(en), .a_i(tm_q[MUL_LAT+1]), .b_i(n4_q), .p_o(pth)
  );

  // threshold is non-negative, drop its sign bit
  assign thr = DW'(pth[THW-2:0]) << COORD_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en) begin
      numd_q   <= -(pe1 + pe2 + pe3);
      nd_q     <= pnd;
      fail_f_q <= f0_q[S_F-1] || (dab_q[MUL_LAT-1] <= thr);
    end
  end

  assign sha = {numa_q[MUL_LAT+1], {SLOPE_FRAC_BITS{1'b0}}};
  assign shb = {numb_q[MUL_LAT+1], {SLOPE_FRAC_BITS{1'b0}}};

  // magnitudes and quotient signs
  always_ff @(posedge clk_i) begin
    if (en) begin
      ana_q    <= sha[ANW-1] ? ANW'(-sha) : ANW'(sha);
      anb_q    <= shb[ANW-1] ? ANW'(-shb) : ANW'(shb);
      ad_q     <= den_q[MUL_LAT+1][DW-1] ? DW'(-den_q[MUL_LAT+1]) : DW'(den_q[MUL_LAT+1]);
      and_q    <= numd_q[EW-1] ? EW'(-numd_q) : EW'(numd_q);
      anden_q  <= nd_q[NDW-1] ? NDW'(-nd_q) : NDW'(nd_q);
      ng_q     <= {numd_q[EW-1] ^ nd_q[NDW-1],
                   numb_q[MUL_LAT+1][DW-1] ^ den_q[MUL_LAT+1][DW-1],
                   numa_q[MUL_LAT+1][DW-1] ^ den_q[MUL_LAT+1][DW-1]};
      fail_g_q <= fail_f_q;
    end
  end

  // round half away: floor((2|n| + |d|) / (2|d|))
  always_ff @(posedge clk_i) begin
    if (en) begin
      na_q     <= {ana_q, 1'b0} + (ANW+1)'(ad_q);
      nb_q     <= {anb_q, 1'b0} + (ANW+1)'(ad_q);
      dab2_q   <= {ad_q, 1'b0};
      nnd_q    <= {and_q, 1'b0} + (EW+1)'(anden_q);
      dnd_q    <= {anden_q, 1'b0};
      fl_q[0]  <= {fail_g_q, ng_q};
      for (int k = 1; k <= DIV_LAT; k++) begin
        fl_q[k] <= fl_q[k-1];
      end
    end
  end

  pfs_div #(.WN(ANW+1), .WD(DW+1)) u_div_a (
    .clk_i, .en_i(en), .num_i(na_q), .den_i(dab2_q), .q_o(qa), .ovf_o(ova)
  );
  pfs_div #(.WN(ANW+1), .WD(DW+1)) u_div_b (
    .clk_i, .en_i(en), .num_i(nb_q), .den_i(dab2_q), .q_o(qb), .ovf_o(ovb)
  );
  pfs_div #(.WN(EW+1), .WD(NDW+1)) u_div_d (
    .clk_i, .en_i(en), .num_i(nnd_q), .den_i(dnd_q), .q_o(qd), .ovf_o(ovd)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      slope_a_q    <= fl_q[DIV_LAT][3] ? 32'sd0 : round_sat(qa, ova, fl_q[DIV_LAT][0]);
      slope_b_q    <= fl_q[DIV_LAT][3] ? 32'sd0 : round_sat(qb, ovb, fl_q[DIV_LAT][1]);
      offset_d_q   <= fl_q[DIV_LAT][3] ? 32'sd0 : round_sat(qd, ovd, fl_q[DIV_LAT][2]);
      fit_failed_q <= fl_q[DIV_LAT][3];
    end
  end

  assign out_valid_o  = v_q[S_O];
  assign slope_a_o    = slope_a_q;
  assign slope_b_o    = slope_b_q;
  assign offset_d_o   = offset_d_q;
  assign fit_failed_o = fit_failed_q;

  a_stall_only_on_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("request side stalled with no result waiting");

  a_failed_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fit_failed_o |->
      (slope_a_o == 32'sd0) && (slope_b_o == 32'sd0) && (offset_d_o == 32'sd0))
    else $error("failed fit carries nonzero coefficients");

  a_empty_marked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (point_count_i == '0) |=> v_q[0] && f0_q[0])
    else $error("empty point set not flagged at entry");

endmodule

>>> sim/plane_fit_solver_test.sv
`timescale 1ns / 1ps

module plane_fit_solver_test;
  import pfs_pkg::*;

  typedef struct {
    logic [8:0]         pc;
    logic signed [34:0] sx, sy, sz;
    logic [59:0]        sxx, syy;
    logic signed [60:0] sxy, syz, sxz;
    logic [26:0]        mx, my;
  } fit_req_t;

  typedef struct {
    logic signed [31:0] a, b, d;
    logic               failed;
  } fit_res_t;

  class fit_scoreboard;
    logic [15:0] tolerance;
    fit_res_t    pending[$];
    int          errors;

    function new();
      tolerance = 16'd1;
      errors    = 0;
    endfunction

    // round half away from zero, then clamp to 32 bits
    function logic signed [31:0] quot_round(logic signed [255:0] num, logic signed [255:0] den);
      logic [255:0] an, ad, q, lim;
      logic [31:0]  m;
      logic         neg;
      neg = num[255] ^ den[255];
      an  = num[255] ? -num : num;
      ad  = den[255] ? -den : den;
      q   = (2 * an + ad) / (2 * ad);
      lim = neg ? 256'h8000_0000 : 256'h7fff_ffff;
      m   = (q > lim) ? lim[31:0] : q[31:0];
      return neg ? (32'd0 - m) : m;
    endfunction

    function void note(fit_req_t r);
      logic signed [255:0] n, sx, sy, sz, sxx, syy, sxy, syz, sxz;
      logic signed [255:0] cxx, cyy, cxy, cyz, cxz, det, numa, numb, numd;
      logic [255:0]        thr, adet;
      fit_res_t            e;
      e = '{a: 0, b: 0, d: 0, failed: 1'b1};
      if (r.pc != 0 && r.pc <= MAX_POINTS) begin
        n    = $signed({247'd0, r.pc});
        sx   = r.sx;  sy = r.sy;  sz = r.sz;
        sxx  = $signed({196'd0, r.sxx});
        syy  = $signed({196'd0, r.syy});
        sxy  = r.sxy; syz = r.syz; sxz = r.sxz;
        cxx  = n * sxx - sx * sx;
        cyy  = n * syy - sy * sy;
        cxy  = n * sxy - sx * sy;
        cyz  = n * syz - sy * sz;
        cxz  = n * sxz - sx * sz;
        det  = cxx * cyy - cxy * cxy;
        adet = det[255] ? -det : det;
        thr  = 256'(tolerance) * (256'(r.mx) + 256'(r.my)) * n * n * n * n;
        thr  = thr << COORD_FRAC_BITS;
        if (adet > thr) begin
          numa = cyz * cxy - cxz * cyy;
          numb = cxz * cxy - cyz * cxx;
          numd = -(sz * det + numa * sx + numb * sy);
          e.a  = quot_round(numa <<< SLOPE_FRAC_BITS, det);
          e.b  = quot_round(numb <<< SLOPE_FRAC_BITS, det);
          e.d  = quot_round(numd, n * det);
          e.failed = 1'b0;
        end
      end
      pending.push_back(e);
    endfunction

    function void check(fit_res_t got);
      fit_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result a=%h b=%h d=%h failed=%b", $time,
                 got.a, got.b, got.d, got.failed);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.a !== e.a) begin
        $display("%0t: slope_a expected %h actual %h", $time, e.a, got.a);
        errors++;
      end
      if (got.b !== e.b) begin
        $display("%0t: slope_b expected %h actual %h", $time, e.b, got.b);
        errors++;
      end
      if (got.d !== e.d) begin
        $display("%0t: offset_d expected %h actual %h", $time, e.d, got.d);
        errors++;
      end
      if (got.failed !== e.failed) begin
        $display("%0t: fit_failed expected %b actual %b", $time, e.failed, got.failed);
        errors++;
      end
    endfunction
  endclass

  localparam int PIPE_DRAIN = 70;
  localparam int WATCHDOG   = 20000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [31:0] slope_a_o, slope_b_o, offset_d_o;
  logic fit_failed_o;
  fit_req_t req;
  fit_scoreboard sb;
  bit   taken;
  int   idle_cycles;
  int   stall_mode;

  plane_fit_solver u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o,
    .point_count_i(req.pc), .sum_x_i(req.sx), .sum_y_i(req.sy), .sum_z_i(req.sz),
    .sum_xx_i(req.sxx), .sum_yy_i(req.syy),
    .sum_xy_i(req.sxy), .sum_yz_i(req.syz), .sum_xz_i(req.sxz),
    .max_abs_x_i(req.mx), .max_abs_y_i(req.my),
    .out_valid_o, .out_stall_i,
    .slope_a_o, .slope_b_o, .offset_d_o, .fit_failed_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid_i && !in_stall_o) begin
        sb.note(req);
        taken = 1'b1;
        idle_cycles = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check('{a: slope_a_o, b: slope_b_o, d: offset_d_o, failed: fit_failed_o});
        idle_cycles = 0;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver stall pattern: switches between free flow, sparse, heavy and long runs
  always @(negedge clk_i) begin
    if ($urandom_range(0, 299) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 2);
      2: out_stall_i <= ($urandom_range(0, 9) < 7);
      default: begin
        if ($urandom_range(0, 15) == 0) out_stall_i <= ~out_stall_i;
      end
    endcase
  end

  task automatic send(fit_req_t r);
    req = r;
    in_valid_i = 1'b1;
    taken = 1'b0;
    do @(negedge clk_i); while (!taken);
  endtask

  task automatic gap(int cycles);
    if (cycles > 0) begin
      in_valid_i = 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (PIPE_DRAIN) @(negedge clk_i);
  endtask

  task automatic set_tolerance(logic [15:0] value);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    sb.tolerance = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // accumulate sums from a point cloud on a noisy plane
  function automatic fit_req_t points(int n, int span, int slope_x, int slope_y,
                                      int noise, bit collinear);
    fit_req_t r;
    longint x, y, z, lim;
    longint sx, sy, sz, sxx, syy, sxy, syz, sxz, mx, my;
    int off;
    lim = 64'sd1 << 25;
    off = $urandom_range(0, 2 * span) - span;
    sx = 0; sy = 0; sz = 0; sxx = 0; syy = 0; sxy = 0; syz = 0; sxz = 0; mx = 0; my = 0;
    for (int i = 0; i < n; i++) begin
      x = longint'($urandom_range(0, 2 * span)) - span;
      y = collinear ? x : longint'($urandom_range(0, 2 * span)) - span;
      z = ((slope_x * x + slope_y * y) >>> 10) + off +
          longint'($urandom_range(0, 2 * noise)) - noise;
      if (z > lim) z = lim;
      if (z < -lim) z = -lim;
      sx += x; sy += y; sz += z;
      sxx += x * x; syy += y * y; sxy += x * y; syz += y * z; sxz += x * z;
      if ((x < 0 ? -x : x) > mx) mx = x < 0 ? -x : x;
      if ((y < 0 ? -y : y) > my) my = y < 0 ? -y : y;
    end
    r.pc = n[8:0];
    r.sx = sx[34:0]; r.sy = sy[34:0]; r.sz = sz[34:0];
    r.sxx = sxx[59:0]; r.syy = syy[59:0];
    r.sxy = sxy[60:0]; r.syz = syz[60:0]; r.sxz = sxz[60:0];
    r.mx = mx[26:0]; r.my = my[26:0];
    return r;
  endfunction

  function automatic fit_req_t raw_req(int pc);
    fit_req_t r;
    r.pc  = pc[8:0];
    r.sx  = 35'({$urandom, $urandom});
    r.sy  = 35'({$urandom, $urandom});
    r.sz  = 35'({$urandom, $urandom});
    r.sxx = 60'({$urandom, $urandom});
    r.syy = 60'({$urandom, $urandom});
    r.sxy = 61'({$urandom, $urandom});
    r.syz = 61'({$urandom, $urandom});
    r.sxz = 61'({$urandom, $urandom});
    r.mx  = 27'($urandom);
    r.my  = 27'($urandom);
    return r;
  endfunction

  function automatic fit_req_t random_req();
    int pick, n;
    pick = $urandom_range(0, 99);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, MAX_POINTS) : $urandom_range(3, 12);
    if (pick < 60)
      return points(n, $urandom_range(1, 1 << 25), $urandom_range(0, 4096) - 2048,
                    $urandom_range(0, 4096) - 2048, $urandom_range(0, 4096), 1'b0);
    if (pick < 70)
      return points(n, $urandom_range(1, 64), $urandom_range(0, 1 << 20) - (1 << 19),
                    $urandom_range(0, 1 << 20) - (1 << 19), $urandom_range(0, 1 << 16), 1'b0);
    if (pick < 78)
      return points($urandom_range(1, 8), $urandom_range(1, 1 << 20), 300, -700, 100,
                    $urandom_range(0, 1));
    if (pick < 95)
      return raw_req($urandom_range(1, MAX_POINTS));
    return raw_req($urandom_range(0, 511));
  endfunction

  task automatic random_phase(int items);
    int burst;
    burst = 0;
    for (int i = 0; i < items; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
      end
      send(random_req());
      burst--;
    end
  endtask

  initial begin
    fit_req_t r;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    stall_mode = 0;
    idle_cycles = 0;
    req = raw_req(0);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty set, count beyond limit, single point
    send(raw_req(0));
    send(raw_req(MAX_POINTS + 1));
    send(raw_req(511));
    send(points(1, 1000, 10, 10, 0, 1'b0));
    // all-ones and all-zero extremes of every sum and max field
    r = raw_req(MAX_POINTS);
    r.sx = '1; r.sy = '1; r.sz = '1; r.sxx = '1; r.syy = '1;
    r.sxy = '1; r.syz = '1; r.sxz = '1; r.mx = '1; r.my = '1;
    send(r);
    r.sx = {1'b1, 34'd0}; r.sy = {1'b0, {34{1'b1}}}; r.sz = {1'b1, 34'd0};
    r.sxx = '1; r.syy = '0; r.sxy = {1'b1, 60'd0}; r.syz = {1'b0, {60{1'b1}}};
    r.sxz = {1'b1, 60'd0}; r.mx = 27'd67108864; r.my = '0;
    send(r);
    r = raw_req(MAX_POINTS);
    r.sx = '0; r.sy = '0; r.sz = '0; r.sxx = '0; r.syy = '0;
    r.sxy = '0; r.syz = '0; r.sxz = '0; r.mx = '0; r.my = '0;
    send(r);
    // clean planes, small and full counts; tiny spread drives the slopes to saturate
    send(points(3, 1 << 16, 512, -256, 0, 1'b0));
    send(points(MAX_POINTS, 1 << 25, -1000, 2000, 50, 1'b0));
    send(points(4, 2, 1 << 20, -(1 << 20), 1 << 20, 1'b0));
    send(points(5, 1 << 20, 0, 0, 0, 1'b1));
    // inconsistent sums with a negative determinant
    r = raw_req(4);
    r.sx = '0; r.sy = '0; r.sz = 35'sd1000; r.sxx = 60'd1; r.syy = 60'd1;
    r.sxy = 61'sd1 << 40; r.syz = 61'sd12345; r.sxz = -61'sd777; r.mx = 27'd1; r.my = 27'd1;
    send(r);

    set_tolerance(16'd0);
    send(points(6, 1 << 20, 0, 0, 0, 1'b1));
    send(points(6, 1 << 12, 100, 100, 10, 1'b0));
    random_phase(160);

    set_tolerance(16'hffff);
    send(points(3, 4, 1, 1, 0, 1'b0));
    random_phase(160);

    set_tolerance(16'd1);
    random_phase(160);

    set_tolerance(16'($urandom_range(2, 65534)));
    random_phase(160);

    set_tolerance(16'($urandom));
    random_phase(160);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
